// ===== design/windowed_metric_stats_alert_defines.svh =====
// Assertion macros shared by the windowed metric statistics block.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef WINDOWED_METRIC_STATS_ALERT_DEFINES_SVH
`define WINDOWED_METRIC_STATS_ALERT_DEFINES_SVH

// check an implication at every clock outside reset
`define WMSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never occurs outside reset
`define WMSA_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/wmsa_pkg.sv =====
// Shared types and constants of the windowed metric statistics block.
// No dependencies.
package wmsa_pkg;

  localparam int unsigned WMSA_WINDOW_DEPTH = 1024;
  localparam int unsigned WMSA_METRIC_COUNT = 16;

  localparam int unsigned IDX_W    = 4;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned FILL_W   = 11;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned CFG_A_W  = 3;
  localparam int unsigned CFG_D_W  = 16;
  localparam int unsigned IN_D_W   = 24;
  localparam int unsigned OUT_D_W  = 64;
  localparam int unsigned WLEN_MIN = 10;

  typedef enum logic [CFG_A_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_HIGH_WARNING  = 3'd1,
    REG_HIGH_CRITICAL = 3'd2,
    REG_HIGH_EMERG    = 3'd3,
    REG_LOW_WARNING   = 3'd4,
    REG_LOW_CRITICAL  = 3'd5,
    REG_LOW_EMERG     = 3'd6,
    REG_LOWER_MASK    = 3'd7
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] LEVEL_INFO      = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_WARNING   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL  = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_EMERGENCY = 2'd3;

  typedef struct packed {
    logic load;
    logic store;
    logic scan;
    logic div_start;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
  } ctrl_sts_t;

endpackage

// ===== design/wmsa_dpath.sv =====
// Datapath: configuration registers, per-metric ring store, window scan and
// serial divider. Depends on wmsa_pkg; sequenced by wmsa_ctrl.
module wmsa_dpath
  import wmsa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WMSA_WINDOW_DEPTH,
  parameter int unsigned METRIC_COUNT = WMSA_METRIC_COUNT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_A_W-1:0]        cfg_addr,
  input  logic [CFG_D_W-1:0]        cfg_data,
  input  logic [IDX_W-1:0]          in_metric_index,
  input  logic signed [VAL_W-1:0]   in_sample_value,
  input  ctrl_cmd_t                 cmd,
  output ctrl_sts_t                 sts,
  output logic signed [VAL_W-1:0]   window_min,
  output logic signed [VAL_W-1:0]   window_max,
  output logic signed [VAL_W-1:0]   window_mean,
  output logic [FILL_W-1:0]         fill_level,
  output logic [LEVEL_W-1:0]        alert_level,
  output logic                      alert_flag
);

  localparam int unsigned MIDX_W   = (METRIC_COUNT > 1) ? $clog2(METRIC_COUNT) : 1;
  localparam int unsigned POS_W    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W    = VAL_W + FILL_W;
  localparam int unsigned DCNT_W   = $clog2(SUM_W + 1);
  localparam int unsigned WLEN_RST = (1000 > WINDOW_DEPTH) ? WINDOW_DEPTH : 1000;
  localparam int unsigned MCNT_W   = $clog2(METRIC_COUNT + 1);

  function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if ({{MCNT_W{1'b0}}, r} >= (MCNT_W + IDX_W)'(METRIC_COUNT)) begin
        r = r - IDX_W'(METRIC_COUNT);
      end
    end
    return r;
  endfunction

  logic [FILL_W-1:0]        wlen_r;
  logic signed [VAL_W-1:0]  hw_r, hc_r, he_r, lw_r, lc_r, le_r;
  logic [CFG_D_W-1:0]       mask_r;
  logic [FILL_W-1:0]        fill_cnt_r [METRIC_COUNT];
  logic [POS_W-1:0]         slot_r     [METRIC_COUNT];
  logic signed [VAL_W-1:0]  mem        [METRIC_COUNT][WINDOW_DEPTH];

  logic [MIDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [POS_W-1:0]         pos_r;
  logic [FILL_W-1:0]        cnt_r;
  logic [FILL_W-1:0]        fill_r;
  logic signed [VAL_W-1:0]  rd_data_r;
  logic                     rd_vld_r;
  logic signed [VAL_W-1:0]  lo_r, hi_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [LEVEL_W-1:0]       level_r;
  logic                     neg_r;
  logic [SUM_W-1:0]         q_r;
  logic [FILL_W-1:0]        rem_r;
  logic [DCNT_W-1:0]        dcnt_r;

  logic [FILL_W-1:0]        len_in, len_sat;
  logic                     len_ok;
  logic [POS_W-1:0]         slot_cur, slot_inc, pos_dec;
  logic [FILL_W:0]          fc_inc;
  logic [FILL_W-1:0]        fill_new;
  logic                     low_bad;
  logic [LEVEL_W-1:0]       level_nxt;
  logic [FILL_W+1:0]        trial, diff;
  logic [SUM_W-1:0]         mean_full;

  assign len_in  = cfg_data[FILL_W-1:0];
  assign len_ok  = len_in >= FILL_W'(WLEN_MIN);
  assign len_sat = (int'(len_in) > WINDOW_DEPTH) ? FILL_W'(WINDOW_DEPTH) : len_in;

  assign slot_cur = slot_r[idx_r];
  assign slot_inc = (int'(slot_cur) == WINDOW_DEPTH - 1) ? '0 : slot_cur + 1'b1;
  assign pos_dec  = (pos_r == '0) ? POS_W'(WINDOW_DEPTH - 1) : pos_r - 1'b1;
  assign fc_inc   = {1'b0, fill_cnt_r[idx_r]} + 1'b1;
  assign fill_new = (fc_inc > {1'b0, wlen_r}) ? wlen_r : fc_inc[FILL_W-1:0];

  assign low_bad = mask_r[IDX_W'(idx_r)];

  always_comb begin
    level_nxt = LEVEL_INFO;
    if (low_bad) begin
      if (val_r <= le_r)      level_nxt = LEVEL_EMERGENCY;
      else if (val_r <= lc_r) level_nxt = LEVEL_CRITICAL;
      else if (val_r <= lw_r) level_nxt = LEVEL_WARNING;
    end else begin
      if (val_r >= he_r)      level_nxt = LEVEL_EMERGENCY;
      else if (val_r >= hc_r) level_nxt = LEVEL_CRITICAL;
      else if (val_r >= hw_r) level_nxt = LEVEL_WARNING;
    end
  end

  assign trial     = {1'b0, rem_r, q_r[SUM_W-1]};
  assign diff      = trial - {2'b0, fill_r};
  assign mean_full = neg_r ? (~q_r + 1'b1) : q_r;

  assign sts.scan_last = (cnt_r == FILL_W'(1));
  assign sts.div_done  = (dcnt_r == DCNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= FILL_W'(WLEN_RST);
      hw_r   <= 16'sd75;
      hc_r   <= 16'sd90;
      he_r   <= 16'sd95;
      lw_r   <= 16'sd30;
      lc_r   <= 16'sd15;
      le_r   <= 16'sd5;
      mask_r <= 16'h0A00;
      for (int m = 0; m < METRIC_COUNT; m++) begin
        fill_cnt_r[m] <= '0;
        slot_r[m]     <= '0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_WINDOW_LENGTH: begin
            if (len_ok) begin
              wlen_r <= len_sat;
              for (int m = 0; m < METRIC_COUNT; m++) begin
                if (fill_cnt_r[m] > len_sat) fill_cnt_r[m] <= len_sat;
              end
            end
          end
          REG_HIGH_WARNING:  hw_r   <= cfg_data;
          REG_HIGH_CRITICAL: hc_r   <= cfg_data;
          REG_HIGH_EMERG:    he_r   <= cfg_data;
          REG_LOW_WARNING:   lw_r   <= cfg_data;
          REG_LOW_CRITICAL:  lc_r   <= cfg_data;
          REG_LOW_EMERG:     le_r   <= cfg_data;
          REG_LOWER_MASK:    mask_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.store) begin
        slot_r[idx_r]     <= slot_inc;
        fill_cnt_r[idx_r] <= fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) mem[idx_r][slot_cur] <= val_r;
    if (cmd.scan)  rd_data_r <= mem[idx_r][pos_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= MIDX_W'(wrap_index(in_metric_index));
      val_r <= in_sample_value;
    end
    if (cmd.store) begin
      pos_r   <= slot_cur;
      cnt_r   <= fill_new;
      fill_r  <= fill_new;
      lo_r    <= val_r;
      hi_r    <= val_r;
      sum_r   <= '0;
      level_r <= level_nxt;
    end
    if (cmd.scan) begin
      pos_r <= pos_dec;
      cnt_r <= cnt_r - 1'b1;
    end
    if (rd_vld_r) begin
      sum_r <= sum_r + SUM_W'(rd_data_r);
      if (rd_data_r < lo_r) lo_r <= rd_data_r;
      if (rd_data_r > hi_r) hi_r <= rd_data_r;
    end
    if (cmd.div_start) begin
      neg_r  <= sum_r[SUM_W-1];
      q_r    <= sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(SUM_W);
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (!diff[FILL_W+1]) begin
        rem_r <= diff[FILL_W-1:0];
        q_r   <= {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[FILL_W-1:0];
        q_r   <= {q_r[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      window_min  <= lo_r;
      window_max  <= hi_r;
      window_mean <= mean_full[VAL_W-1:0];
      fill_level  <= fill_r;
      alert_level <= level_r;
      alert_flag  <= (level_r != LEVEL_INFO);
    end
  end

endmodule

// ===== design/wmsa_ctrl.sv =====
// Controller: sequences load, store, window scan, divide and result hand-off.
// Depends on wmsa_pkg and the assertion macros; drives wmsa_dpath.
`include "windowed_metric_stats_alert_defines.svh"
module wmsa_ctrl
  import wmsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DIV_START;
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WMSA_ASSERT(a_one_in_flight, (in_tvalid && in_tready) |=> !in_tready, "second word taken")
  `WMSA_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_tready), "result overwritten")
  `WMSA_ASSERT(a_result_shown, cmd.out_load |=> out_tvalid, "result not presented")
  `WMSA_NEVER(a_cmd_excl, !$onehot0({cmd.load, cmd.store, cmd.scan, cmd.div_start, cmd.div_step, cmd.out_load}), "overlapping commands")

endmodule

// ===== design/windowed_metric_stats_alert.sv =====
// Windowed metric statistics with alert grading. Each input word carries one
// sample for one metric; the block stores it in that metric's ring, then reads
// the window back one entry per cycle over the single store read port and
// divides the sum with a one-bit-per-cycle divider. The next word is taken while
// the previous result still waits on the output register. No clearing pass.
module windowed_metric_stats_alert
  import wmsa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WMSA_WINDOW_DEPTH,
  parameter int unsigned METRIC_COUNT = WMSA_METRIC_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  // metric_index[3:0], sample_value[19:4], zero pad
  input  logic [IN_D_W-1:0]   in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // window_min[15:0], window_max[31:16], window_mean[47:32], fill_level[58:48],
  // alert_level[60:59], alert_flag[61], zero pad
  output logic [OUT_D_W-1:0]  out_tdata
);

  ctrl_cmd_t               cmd;
  ctrl_sts_t               sts;
  logic signed [VAL_W-1:0] window_min, window_max, window_mean;
  logic [FILL_W-1:0]       fill_level;
  logic [LEVEL_W-1:0]      alert_level;
  logic                    alert_flag;

  wmsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wmsa_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .METRIC_COUNT (METRIC_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .in_metric_index (in_tdata[IDX_W-1:0]),
    .in_sample_value (in_tdata[IDX_W+VAL_W-1:IDX_W]),
    .cmd             (cmd),
    .sts             (sts),
    .window_min      (window_min),
    .window_max      (window_max),
    .window_mean     (window_mean),
    .fill_level      (fill_level),
    .alert_level     (alert_level),
    .alert_flag      (alert_flag)
  );

  assign out_tdata = {2'b00, alert_flag, alert_level, fill_level,
                      window_mean, window_max, window_min};

endmodule

// ===== bench/windowed_metric_stats_alert_test.sv =====
// Self-checking bench for windowed_metric_stats_alert: samples go in as words, and each result
// word is checked against an in-bench prediction of window min, max, mean, fill and alert grade.
// Depends on wmsa_pkg and the windowed_metric_stats_alert RTL only.
module windowed_metric_stats_alert_test;
  import wmsa_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]        metric;
    logic signed [VAL_W-1:0] value;
  } sample_t;

  typedef struct {
    logic signed [VAL_W-1:0] wmin;
    logic signed [VAL_W-1:0] wmax;
    logic signed [VAL_W-1:0] wmean;
    logic [FILL_W-1:0]       fill;
    logic [LEVEL_W-1:0]      level;
    logic                    flag;
  } stats_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_A_W-1:0]  cfg_addr;
  logic [CFG_D_W-1:0]  cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_D_W-1:0]   in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_D_W-1:0]  out_tdata;

  windowed_metric_stats_alert uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predicted block state
  logic signed [VAL_W-1:0] ring [WMSA_METRIC_COUNT][WMSA_WINDOW_DEPTH];
  int unsigned             held [WMSA_METRIC_COUNT];
  int unsigned             next_slot [WMSA_METRIC_COUNT];
  int unsigned             win_len;
  logic signed [VAL_W-1:0] hi_warn, hi_crit, hi_emerg, lo_warn, lo_crit, lo_emerg;
  logic [VAL_W-1:0]        low_bad_mask;

  sample_t     samples_pending [$];
  stats_t      stats_expected [$];
  int          errors = 0;
  bit          word_taken = 0;
  bit          idling = 1;
  bit          stall_req = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          rx_stall_left = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("windowed_metric_stats_alert_test: done, errors");
    $finish;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic stats_t grade_sample(sample_t s);
    stats_t r;
    int unsigned m, pos;
    longint total;
    logic signed [VAL_W-1:0] x;
    bit low_bad;
    m = s.metric;
    ring[m][next_slot[m]] = s.value;
    next_slot[m] = (next_slot[m] + 1) % WMSA_WINDOW_DEPTH;
    held[m] = (held[m] + 1 > win_len) ? win_len : held[m] + 1;
    r.wmin = s.value;
    r.wmax = s.value;
    total = 0;
    pos = next_slot[m];
    for (int i = 0; i < held[m]; i++) begin
      pos = (pos + WMSA_WINDOW_DEPTH - 1) % WMSA_WINDOW_DEPTH;
      x = ring[m][pos];
      total += x;
      if (x < r.wmin) r.wmin = x;
      if (x > r.wmax) r.wmax = x;
    end
    r.wmean = VAL_W'(total / longint'(held[m]));
    r.fill = FILL_W'(held[m]);
    low_bad = low_bad_mask[m];
    if (low_bad) begin
      if (s.value <= lo_emerg) r.level = LEVEL_EMERGENCY;
      else if (s.value <= lo_crit) r.level = LEVEL_CRITICAL;
      else if (s.value <= lo_warn) r.level = LEVEL_WARNING;
      else r.level = LEVEL_INFO;
    end else begin
      if (s.value >= hi_emerg) r.level = LEVEL_EMERGENCY;
      else if (s.value >= hi_crit) r.level = LEVEL_CRITICAL;
      else if (s.value >= hi_warn) r.level = LEVEL_WARNING;
      else r.level = LEVEL_INFO;
    end
    r.flag = (r.level != LEVEL_INFO);
    return r;
  endfunction

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    sample_t s;
    if (rst_n && in_tvalid && in_tready) begin
      s = samples_pending[0];
      samples_pending.delete(0);
      stats_expected.insert(stats_expected.size(), grade_sample(s));
      word_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!(in_tvalid && !word_taken)) begin
      word_taken = 0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (samples_pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, samples_pending[0].value, samples_pending[0].metric};
        if (idling && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 11);
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_req) begin
        stall_req = 0;
        rx_stall_left = 3000;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idling && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (stats_expected.size() == 0) begin
        report("unexpected word", longint'(out_tdata), 0);
      end else begin
        want = stats_expected[0];
        stats_expected.delete(0);
        if (out_tdata[15:0] !== want.wmin)
          report("window_min", $signed(out_tdata[15:0]), want.wmin);
        if (out_tdata[31:16] !== want.wmax)
          report("window_max", $signed(out_tdata[31:16]), want.wmax);
        if (out_tdata[47:32] !== want.wmean)
          report("window_mean", $signed(out_tdata[47:32]), want.wmean);
        if (out_tdata[58:48] !== want.fill) report("fill_level", out_tdata[58:48], want.fill);
        if (out_tdata[60:59] !== want.level) report("alert_level", out_tdata[60:59], want.level);
        if (out_tdata[61] !== want.flag) report("alert_flag", out_tdata[61], want.flag);
        if (out_tdata[63:62] !== 2'b0) report("pad", out_tdata[63:62], 0);
      end
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_D_W-1:0] d);
    int unsigned len;
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= r;
    cfg_data  <= d;
    case (r)
      REG_WINDOW_LENGTH: begin
        len = d[FILL_W-1:0];
        if (len >= WLEN_MIN) begin
          if (len > WMSA_WINDOW_DEPTH) len = WMSA_WINDOW_DEPTH;
          win_len = len;
          foreach (held[m]) if (held[m] > len) held[m] = len;
        end
      end
      REG_HIGH_WARNING:  hi_warn = d;
      REG_HIGH_CRITICAL: hi_crit = d;
      REG_HIGH_EMERG:    hi_emerg = d;
      REG_LOW_WARNING:   lo_warn = d;
      REG_LOW_CRITICAL:  lo_crit = d;
      REG_LOW_EMERG:     lo_emerg = d;
      REG_LOWER_MASK:    low_bad_mask = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_sample(int metric, int value);
    sample_t s;
    s.metric = IDX_W'(metric);
    s.value  = VAL_W'(value);
    samples_pending.insert(samples_pending.size(), s);
  endtask

  task automatic drain();
    while (samples_pending.size() != 0 || stats_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [CFG_D_W-1:0] pick_level(int mode);
    case (mode)
      0: return CFG_D_W'($urandom_range(0, 240) - 120);
      1: return 16'h8000;
      2: return 16'h7FFF;
      default: return CFG_D_W'($urandom);
    endcase
  endfunction

  initial begin
    int wlens [7] = '{9, 12, 2047, 10, 1024, 30, 500};
    int mode;
    cfg_wr_en = 0;
    cfg_addr  = '0;
    cfg_data  = '0;
    in_tvalid = 0;
    in_tdata  = '0;
    out_tready = 0;
    rst_n = 0;
    foreach (held[m]) begin
      held[m] = 0;
      next_slot[m] = 0;
    end
    win_len = 1000;
    hi_warn = 75; hi_crit = 90; hi_emerg = 95;
    lo_warn = 30; lo_crit = 15; lo_emerg = 5;
    low_bad_mask = 16'h0A00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (wlens[i]) if (i < 5) push_sample(0, 74 + 5 * i - (i > 0 ? i : 0));
    push_sample(0, 95); push_sample(0, 96); push_sample(0, 32767); push_sample(0, -32768);
    push_sample(0, 0); push_sample(0, -1); push_sample(0, 1);
    push_sample(0, 16'h5555); push_sample(0, -21846);
    push_sample(9, 31); push_sample(9, 30); push_sample(9, 16); push_sample(9, 15);
    push_sample(9, 6); push_sample(9, 5); push_sample(9, -32768);
    push_sample(15, 32767); push_sample(11, 100); push_sample(4, 90);
    drain();

    for (int p = 0; p < 7; p++) begin
      mode = p % 4;
      write_reg(REG_WINDOW_LENGTH, CFG_D_W'(wlens[p]));
      write_reg(REG_HIGH_WARNING, pick_level(mode));
      write_reg(REG_HIGH_CRITICAL, pick_level(mode == 0 ? 0 : 3 - mode + 1));
      write_reg(REG_HIGH_EMERG, pick_level(mode));
      write_reg(REG_LOW_WARNING, pick_level(mode));
      write_reg(REG_LOW_CRITICAL, pick_level(mode == 0 ? 0 : 3));
      write_reg(REG_LOW_EMERG, pick_level(mode));
      write_reg(REG_LOWER_MASK, p == 1 ? 16'h0000 : p == 2 ? 16'hFFFF : 16'($urandom));
      if (p == 1) stall_req = 1;
      if (p == 6) idling = 0;
      for (int k = 0; k < 78; k++) begin
        if ($urandom_range(0, 1))
          push_sample($urandom_range(0, 15), $urandom_range(0, 240) - 120);
        else
          push_sample($urandom_range(0, 15), $urandom);
      end
      drain();
    end

    if (errors == 0) begin
      $display("windowed_metric_stats_alert_test: done, clean");
    end else begin
      $display("windowed_metric_stats_alert_test: done, errors");
    end
    $finish;
  end

endmodule
